// ===== design/i2csbe_pkg.sv =====
// Shared types, codes and sizes for the I2C slave byte engine.
package i2csbe_pkg;

    localparam int unsigned BUFFER_DEPTH = 16;
    localparam int unsigned IDX_W        = $clog2(BUFFER_DEPTH);
    localparam int unsigned CNT_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned DATA_W       = 8;
    localparam int unsigned ADDR7_W      = 7;

    typedef enum logic [2:0] {
        OP_START   = 3'd0,
        OP_STOP    = 3'd1,
        OP_BYTE    = 3'd2,
        OP_ACK_BIT = 3'd3,
        OP_LOAD_TX = 3'd4,
        OP_READ_RX = 3'd5
    } opcode_t;

    typedef enum logic [2:0] {
        RSP_NONE = 3'd0,
        RSP_ACK  = 3'd1,
        RSP_NACK = 3'd2,
        RSP_TX   = 3'd3,
        RSP_HOST = 3'd4
    } rsp_t;

    typedef enum logic [1:0] {
        BP_IDLE  = 2'd0,
        BP_ADDR  = 2'd1,
        BP_WRITE = 2'd2,
        BP_READ  = 2'd3
    } bus_phase_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_ADDR  = 4'b0010,
        PH_WRITE = 4'b0100,
        PH_READ  = 4'b1000
    } phase_t;

    function automatic bus_phase_t phase_code(input phase_t ph);
        bus_phase_t code;
        unique case (ph)
            PH_IDLE:  code = BP_IDLE;
            PH_ADDR:  code = BP_ADDR;
            PH_WRITE: code = BP_WRITE;
            PH_READ:  code = BP_READ;
            default:  code = BP_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ===== design/i2csbe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module i2csbe_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/i2c_slave_byte_engine_unit.sv =====
// I2C slave byte engine: bus event decode, receive/transmit stores, result output.
//
// One request is taken per clock unless back-pressure or a pending second result holds the input.
// Every request gives one result, except an address byte that matches with the read bit set,
// which gives an ACK and then the first transmit byte; that request holds the input until
// its ACK has moved into the output register. A result passes through the store read (both
// stores are synchronous RAMs read when the request is taken) and then the output register.
// Receive entries not written since the last START read as zero through the fill count;
// transmit entries never loaded read as zero through a valid bit per entry. No clearing pass after reset.
module i2c_slave_byte_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,   // own_address
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,       // [7:0] data_in, [11:8] entry_index, [15:12] zero
    input  logic [2:0]  s_tuser,       // [2:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // [7:0] data_out, [12:8] rx_fill, [14:13] bus_phase,
                                       // [15] zero
    output logic [2:0]  m_tuser,       // [2:0] response
    output logic        m_tlast        // last_result
);

    localparam int unsigned DW = i2csbe_pkg::DATA_W;
    localparam int unsigned IW = i2csbe_pkg::IDX_W;
    localparam int unsigned CW = i2csbe_pkg::CNT_W;

    // control state
    logic [i2csbe_pkg::ADDR7_W-1:0] own_address_reg;
    i2csbe_pkg::phase_t             phase_reg, phase_next;
    logic [CW-1:0]                  rx_count_reg, rx_count_next;
    logic [CW-1:0]                  tx_count_reg, tx_count_next;
    logic [i2csbe_pkg::BUFFER_DEPTH-1:0] tx_valid_reg, tx_valid_next;

    // result stage (store data arrives here)
    logic                    s1_valid_reg, s1_valid_next;
    logic                    s1_two_reg, s1_two_next;
    i2csbe_pkg::rsp_t        s1_rsp_reg;
    logic                    s1_use_mem_reg;
    logic                    s1_src_rx_reg;
    logic                    s1_ff_reg;
    logic [CW-1:0]           s1_fill_reg;
    i2csbe_pkg::bus_phase_t  s1_phase_reg;

    // output register
    logic                    m_valid_reg, m_valid_next;
    i2csbe_pkg::rsp_t        m_rsp_reg;
    logic [DW-1:0]           m_data_reg;
    logic [CW-1:0]           m_fill_reg;
    i2csbe_pkg::bus_phase_t  m_phase_reg;
    logic                    m_last_reg;

    // decode
    i2csbe_pkg::opcode_t     op;
    logic [DW-1:0]           din;
    logic [IW-1:0]           idx;
    logic                    s_accept;
    logic                    out_free;
    logic                    s1_done;
    i2csbe_pkg::rsp_t        rsp_c;
    logic                    two_c, use_mem_c, src_rx_c, ff_c;
    logic                    rx_we, tx_we;
    logic [IW-1:0]           tx_raddr;
    logic [DW-1:0]           rx_dout, tx_dout;
    logic [DW-1:0]           s1_data;

    assign op  = i2csbe_pkg::opcode_t'(s_tuser);
    assign din = s_tdata[DW-1:0];
    assign idx = s_tdata[DW+IW-1:DW];

    assign out_free = !m_valid_reg || m_tready;
    assign s1_done  = s1_valid_reg && out_free && !s1_two_reg;
    assign s_tready = !s1_valid_reg || s1_done;
    assign s_accept = s_tvalid && s_tready;
    assign tx_raddr = tx_count_reg[IW-1:0];

    always_comb begin
        phase_next    = phase_reg;
        rx_count_next = rx_count_reg;
        tx_count_next = tx_count_reg;
        tx_valid_next = tx_valid_reg;
        rsp_c         = i2csbe_pkg::RSP_NONE;
        two_c         = 1'b0;
        use_mem_c     = 1'b0;
        src_rx_c      = 1'b0;
        ff_c          = 1'b0;
        rx_we         = 1'b0;
        tx_we         = 1'b0;
        if (s_accept) begin
            case (op)
                i2csbe_pkg::OP_START: begin
                    rx_count_next = '0;
                    tx_count_next = '0;
                    phase_next    = i2csbe_pkg::PH_ADDR;
                end
                i2csbe_pkg::OP_STOP: begin
                    phase_next = i2csbe_pkg::PH_IDLE;
                end
                i2csbe_pkg::OP_BYTE: begin
                    if (phase_reg == i2csbe_pkg::PH_ADDR) begin
                        if (din[DW-1:1] == own_address_reg) begin
                            if (din[0]) begin
                                phase_next = i2csbe_pkg::PH_READ;
                                two_c      = 1'b1;
                                rsp_c      = i2csbe_pkg::RSP_TX;
                                if (tx_count_reg < CW'(i2csbe_pkg::BUFFER_DEPTH)) begin
                                    use_mem_c     = tx_valid_reg[tx_raddr];
                                    tx_count_next = tx_count_reg + CW'(1);
                                end else begin
                                    ff_c = 1'b1;
                                end
                            end else begin
                                phase_next = i2csbe_pkg::PH_WRITE;
                                rsp_c      = i2csbe_pkg::RSP_ACK;
                            end
                        end else begin
                            phase_next = i2csbe_pkg::PH_IDLE;
                        end
                    end else if (phase_reg == i2csbe_pkg::PH_WRITE) begin
                        if (rx_count_reg < CW'(i2csbe_pkg::BUFFER_DEPTH)) begin
                            rx_we         = 1'b1;
                            rx_count_next = rx_count_reg + CW'(1);
                            rsp_c         = i2csbe_pkg::RSP_ACK;
                        end else begin
                            rsp_c = i2csbe_pkg::RSP_NACK;
                        end
                    end
                end
                i2csbe_pkg::OP_ACK_BIT: begin
                    if (phase_reg == i2csbe_pkg::PH_READ) begin
                        if (din != '0) begin
                            phase_next = i2csbe_pkg::PH_IDLE;
                        end else begin
                            rsp_c = i2csbe_pkg::RSP_TX;
                            if (tx_count_reg < CW'(i2csbe_pkg::BUFFER_DEPTH)) begin
                                use_mem_c     = tx_valid_reg[tx_raddr];
                                tx_count_next = tx_count_reg + CW'(1);
                            end else begin
                                ff_c = 1'b1;
                            end
                        end
                    end
                end
                i2csbe_pkg::OP_LOAD_TX: begin
                    tx_we              = 1'b1;
                    tx_valid_next[idx] = 1'b1;
                end
                i2csbe_pkg::OP_READ_RX: begin
                    rsp_c     = i2csbe_pkg::RSP_HOST;
                    src_rx_c  = 1'b1;
                    use_mem_c = ({1'b0, idx} < rx_count_reg);
                end
                default: begin
                end
            endcase
        end
    end

    i2csbe_ram #(.WIDTH(DW), .DEPTH(i2csbe_pkg::BUFFER_DEPTH)) u_rx_ram (
        .clk   (aclk),
        .we    (rx_we),
        .waddr (rx_count_reg[IW-1:0]),
        .wdata (din),
        .re    (s_accept),
        .raddr (idx),
        .rdata (rx_dout)
    );

    i2csbe_ram #(.WIDTH(DW), .DEPTH(i2csbe_pkg::BUFFER_DEPTH)) u_tx_ram (
        .clk   (aclk),
        .we    (tx_we),
        .waddr (idx),
        .wdata (din),
        .re    (s_accept),
        .raddr (tx_raddr),
        .rdata (tx_dout)
    );

    always_comb begin
        if (s1_ff_reg) begin
            s1_data = '1;
        end else if (s1_use_mem_reg) begin
            s1_data = s1_src_rx_reg ? rx_dout : tx_dout;
        end else begin
            s1_data = '0;
        end
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        s1_two_next   = s1_two_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
            s1_two_next   = two_c;
        end else if (s1_done) begin
            s1_valid_next = 1'b0;
        end else if (s1_valid_reg && out_free) begin
            s1_two_next = 1'b0;
        end
        m_valid_next = out_free ? s1_valid_reg : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_address_reg <= '0;
            phase_reg       <= i2csbe_pkg::PH_IDLE;
            rx_count_reg    <= '0;
            tx_count_reg    <= '0;
            tx_valid_reg    <= '0;
            s1_valid_reg    <= 1'b0;
            s1_two_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                own_address_reg <= cfg_wr_data;
            end
            phase_reg    <= phase_next;
            rx_count_reg <= rx_count_next;
            tx_count_reg <= tx_count_next;
            tx_valid_reg <= tx_valid_next;
            s1_valid_reg <= s1_valid_next;
            s1_two_reg   <= s1_two_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_rsp_reg     <= rsp_c;
            s1_use_mem_reg <= use_mem_c;
            s1_src_rx_reg  <= src_rx_c;
            s1_ff_reg      <= ff_c;
            s1_fill_reg    <= rx_count_next;
            s1_phase_reg   <= i2csbe_pkg::phase_code(phase_next);
        end
        if (out_free && s1_valid_reg) begin
            m_fill_reg  <= s1_fill_reg;
            m_phase_reg <= s1_phase_reg;
            if (s1_two_reg) begin
                m_rsp_reg  <= i2csbe_pkg::RSP_ACK;
                m_data_reg <= '0;
                m_last_reg <= 1'b0;
            end else begin
                m_rsp_reg  <= s1_rsp_reg;
                m_data_reg <= s1_data;
                m_last_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_rsp_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {1'b0, m_phase_reg, m_fill_reg, m_data_reg};

    // only the read-address ACK is followed by a further result
    a_first_of_two: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |->
            m_tuser == i2csbe_pkg::RSP_ACK && m_tdata[14:13] == i2csbe_pkg::BP_READ)
        else $error("non-final result is not a read ACK");

    a_rx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rx_count_reg <= CW'(i2csbe_pkg::BUFFER_DEPTH) &&
        tx_count_reg <= CW'(i2csbe_pkg::BUFFER_DEPTH))
        else $error("counter beyond store depth");

    a_hold_on_two: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && s1_two_reg |-> !s_tready)
        else $error("request taken while a second result is pending");

    a_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == i2csbe_pkg::RSP_NONE || m_tuser == i2csbe_pkg::RSP_ACK ||
                     m_tuser == i2csbe_pkg::RSP_NACK) |-> m_tdata[7:0] == '0)
        else $error("non-data result carries data");

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for i2c_slave_byte_engine_unit: predicted responses checked against the result stream.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2csbe_pkg::*;

    typedef struct {
        rsp_t       rsp;
        logic [7:0] data;
        logic [4:0] fill;
        bus_phase_t ph;
        logic       last;
    } response_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [6:0]  cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = '0;
    logic [2:0]  s_tuser     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    // predicted engine state
    logic [6:0]  addr_setting = '0;
    bus_phase_t  bus_ph       = BP_IDLE;
    logic [7:0]  rx_mem [BUFFER_DEPTH] = '{default: '0};
    logic [7:0]  tx_mem [BUFFER_DEPTH] = '{default: '0};
    int unsigned rx_fill_cnt  = 0;
    int unsigned tx_ptr       = 0;

    response_t   awaited_responses [$];
    int unsigned requests_sent = 0;
    int unsigned mismatches    = 0;
    int unsigned src_idle_pct  = 0;
    int unsigned dst_idle_pct  = 0;
    int unsigned sink_hold_req = 0;

    i2c_slave_byte_engine_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #8_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic void queue_response(rsp_t r, logic [7:0] d, logic last);
        response_t e;
        e.rsp  = r;
        e.data = d;
        e.fill = rx_fill_cnt[4:0];
        e.ph   = bus_ph;
        e.last = last;
        awaited_responses.push_back(e);
    endfunction

    // past the end of the store the byte is 0xFF and the pointer stays put
    function automatic logic [7:0] take_tx_byte();
        logic [7:0] b;
        b = 8'hFF;
        if (tx_ptr < BUFFER_DEPTH) begin
            b = tx_mem[tx_ptr[3:0]];
            tx_ptr++;
        end
        return b;
    endfunction

    function automatic void compute_responses(logic [2:0] op, logic [7:0] d, logic [3:0] idx);
        rsp_t       r;
        logic [7:0] v;
        r = RSP_NONE;
        v = '0;
        case (op)
            OP_START: begin
                foreach (rx_mem[i]) rx_mem[i] = '0;
                rx_fill_cnt = 0;
                tx_ptr      = 0;
                bus_ph      = BP_ADDR;
            end
            OP_STOP: bus_ph = BP_IDLE;
            OP_BYTE: begin
                if (bus_ph == BP_ADDR) begin
                    if (d[7:1] == addr_setting) begin
                        r = RSP_ACK;
                        if (d[0]) begin
                            bus_ph = BP_READ;
                            queue_response(RSP_ACK, '0, 1'b0);
                            r = RSP_TX;
                            v = take_tx_byte();
                        end else begin
                            bus_ph = BP_WRITE;
                        end
                    end else begin
                        bus_ph = BP_IDLE;
                    end
                end else if (bus_ph == BP_WRITE) begin
                    if (rx_fill_cnt < BUFFER_DEPTH) begin
                        rx_mem[rx_fill_cnt[3:0]] = d;
                        rx_fill_cnt++;
                        r = RSP_ACK;
                    end else begin
                        r = RSP_NACK;
                    end
                end
            end
            OP_ACK_BIT: begin
                if (bus_ph == BP_READ) begin
                    if (d != 0) begin
                        bus_ph = BP_IDLE;
                    end else begin
                        r = RSP_TX;
                        v = take_tx_byte();
                    end
                end
            end
            OP_LOAD_TX: tx_mem[idx] = d;
            OP_READ_RX: begin
                r = RSP_HOST;
                v = rx_mem[idx];
            end
            default: ;
        endcase
        queue_response(r, v, 1'b1);
    endfunction

    task automatic send_event(input logic [2:0] op, input logic [7:0] d = '0,
                              input logic [3:0] idx = '0);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'h0, idx, d};
        do @(posedge aclk); while (!s_tready);
        compute_responses(op, d, idx);
        requests_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (awaited_responses.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_own_address(input logic [6:0] a);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= a;
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        addr_setting  = a;
    endtask

    // sink side: random stalls plus an occasional long hold-off
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (sink_hold_req != 0) begin
                hold_left     = sink_hold_req;
                sink_hold_req = 0;
            end
            if (hold_left != 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= dst_idle_pct);
            end
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        response_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_responses.size() == 0) begin
                $error("unexpected response: tuser %0h tdata %0h tlast %0b",
                       m_tuser, m_tdata, m_tlast);
                mismatches++;
            end else begin
                e = awaited_responses.pop_front();
                check_field("response", 8'(e.rsp), 8'(m_tuser));
                check_field("data_out", e.data, m_tdata[7:0]);
                check_field("rx_fill", 8'(e.fill), 8'(m_tdata[12:8]));
                check_field("bus_phase", 8'(e.ph), 8'(m_tdata[14:13]));
                check_field("pad", 8'h00, 8'(m_tdata[15]));
                check_field("last_result", 8'(e.last), 8'(m_tlast));
            end
        end
    end

    task automatic test_directed();
        send_event(OP_READ_RX, 8'h00, 4'd0);
        send_event(OP_BYTE, 8'hFF);          // idle, ignored
        send_event(OP_ACK_BIT, 8'h00);       // not reading, ignored
        send_event(3'd6, 8'hFF, 4'hF);
        send_event(3'd7, 8'h00, 4'h0);
        send_event(OP_LOAD_TX, 8'hFF, 4'd0);
        send_event(OP_LOAD_TX, 8'h5A, 4'd1);
        send_event(OP_START);
        send_event(OP_BYTE, {addr_setting, 1'b0});
        send_event(OP_BYTE, 8'hFF);
        send_event(OP_BYTE, 8'h00);
        send_event(OP_BYTE, 8'hA5);
        send_event(OP_ACK_BIT, 8'h00);       // writing, ignored
        send_event(OP_STOP);
        send_event(OP_READ_RX, 8'h00, 4'd0);
        send_event(OP_READ_RX, 8'hFF, 4'd15);
        send_event(OP_START);
        send_event(OP_BYTE, {addr_setting, 1'b1});
        send_event(OP_ACK_BIT, 8'h00);
        send_event(OP_ACK_BIT, 8'h80);       // master nack
        send_event(OP_START);
        send_event(OP_BYTE, {addr_setting ^ 7'h01, 1'b0});
        send_event(OP_BYTE, 8'h55);
        send_event(OP_STOP);
    endtask

    task automatic test_random_traffic(input logic [6:0] addr, input int unsigned n_req);
        int unsigned stop_at;
        int unsigned len;
        logic [6:0]  a;
        set_own_address(addr);
        stop_at = requests_sent + n_req;
        while (requests_sent < stop_at) begin
            a = addr_setting;
            if ($urandom_range(9) == 0) a = addr_setting ^ 7'($urandom_range(127, 1));
            len = ($urandom_range(3) == 0) ? $urandom_range(20, 14) : $urandom_range(6);
            case ($urandom_range(9))
                0, 1, 2, 3: begin
                    send_event(OP_START);
                    send_event(OP_BYTE, {a, 1'b0});
                    repeat (len) send_event(OP_BYTE, 8'($urandom));
                    if ($urandom_range(4) != 0) send_event(OP_STOP);
                end
                4, 5, 6: begin
                    send_event(OP_START);
                    send_event(OP_BYTE, {a, 1'b1});
                    repeat (len) send_event(OP_ACK_BIT, 8'h00);
                    case ($urandom_range(2))
                        0: send_event(OP_ACK_BIT, 8'($urandom_range(255, 1)));
                        1: send_event(OP_STOP);
                        default: ;
                    endcase
                end
                7: repeat (len) send_event(OP_LOAD_TX, 8'($urandom), 4'($urandom));
                8: repeat (len) send_event(OP_READ_RX, 8'($urandom), 4'($urandom));
                default: repeat (len) send_event(3'($urandom), 8'($urandom), 4'($urandom));
            endcase
        end
    endtask

    // sink stalls long enough for the engine to back up onto its input
    task automatic test_backpressure();
        sink_hold_req = 300;
        send_event(OP_START);
        send_event(OP_BYTE, {addr_setting, 1'b0});
        repeat (8) send_event(OP_BYTE, 8'($urandom));
        repeat (40) send_event(OP_READ_RX, 8'($urandom), 4'($urandom));
        send_event(OP_STOP);
    endtask

    task automatic test_drain_pause();
        send_event(OP_START);
        send_event(OP_BYTE, {addr_setting, 1'b1});
        repeat (3) send_event(OP_ACK_BIT, 8'h00);
        drain();
        send_event(OP_ACK_BIT, 8'h00);
        send_event(OP_ACK_BIT, 8'h01);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        src_idle_pct = 9;
        dst_idle_pct = 73;
        test_directed();
        test_random_traffic(7'h00, 280);
        test_backpressure();
        test_random_traffic(7'h7F, 280);

        src_idle_pct = 73;
        dst_idle_pct = 9;
        test_random_traffic(7'($urandom), 280);
        test_drain_pause();
        test_random_traffic(7'h55, 280);

        src_idle_pct = 0;
        dst_idle_pct = 0;
        test_random_traffic(7'($urandom), 280);
        test_random_traffic(7'h2A, 280);

        drain();
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
design/i2csbe_pkg.sv
design/i2csbe_ram.sv
design/i2c_slave_byte_engine_unit.sv
tb/sv/tb.sv
